### design/fspc_pkg.sv
package fspc_pkg;
	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_STEP = 2'd1;
	localparam logic [1:0] OP_RDMEM = 2'd2;
	localparam logic [1:0] OP_RDREG = 2'd3;

	localparam logic [9:0] OPC_ADD = 10'd0;
	localparam logic [9:0] OPC_NOR = 10'd1;
	localparam logic [9:0] OPC_LW = 10'd2;
	localparam logic [9:0] OPC_SW = 10'd3;
	localparam logic [9:0] OPC_BEQ = 10'd4;
	localparam logic [9:0] OPC_HALT = 10'd6;
	localparam logic [31:0] NOOP_WORD = 32'd7 << 22;

	localparam int IN_W = 56;
	localparam int OUT_W = 160;

	function automatic logic [9:0] opc(input logic [31:0] w);
		return w[31:22];
	endfunction

	function automatic logic writes_reg(input logic [31:0] w, input logic lw_ok);
		return opc(w) == OPC_ADD || opc(w) == OPC_NOR || (lw_ok && opc(w) == OPC_LW);
	endfunction

	function automatic logic [2:0] dest_of(input logic [31:0] w);
		return (opc(w) == OPC_LW) ? w[18:16] : w[2:0];
	endfunction
endpackage

### design/fspc_ram.sv
module fspc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

### design/five_stage_pipeline_cpu.sv
// Channel  Direction  Word, lowest bits first
// s_axis   in         op[1:0], address[17:2], data[49:18], zero pad to 56 bits
// m_axis   out        pc[9:0], cycle_count[41:10], halted[42], wb_valid[43], wb_reg[46:44],
//                     wb_value[78:47], store_valid[79], store_address[89:80],
//                     store_value[121:90], read_value[153:122], zero pad to 160 bits
// An accepted word executes in the next cycle, which also issues the store reads for
// the word behind it; its result word is registered into the output buffer.
// A word can be accepted every cycle while the two-word output buffer has room; the input
// stalls only during the clearing pass or when that buffer and the executing word would
// overflow it. After reset a clearing pass zeroes all MEM_WORDS entries of both stores;
// no word is accepted until it ends.
module five_stage_pipeline_cpu #(
	parameter int MEM_WORDS = 1024
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [fspc_pkg::IN_W-1:0] s_axis_tdata, // op, address, data, zero pad
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [fspc_pkg::OUT_W-1:0] m_axis_tdata // pc, cycle_count, halted,
	// wb_valid, wb_reg, wb_value, store_valid, store_address, store_value, read_value
);
	import fspc_pkg::*;
	localparam int AW = $clog2(MEM_WORDS);

	logic [1:0] op;
	logic [15:0] address;
	logic [31:0] data;
	assign op = s_axis_tdata[1:0];
	assign address = s_axis_tdata[17:2];
	assign data = s_axis_tdata[49:18];

	logic clr_q;
	logic [AW:0] clr_cnt_q;
	logic out_valid_q, skid_valid_q;
	logic [OUT_W-1:0] out_q, skid_q, res_n;
	logic take, pop;
	logic [1:0] occ_n;

	logic pend_q;
	logic [1:0] pend_op_q;
	logic [2:0] pend_reg_q;
	logic [AW-1:0] pend_addr_q;
	logic [31:0] pend_data_q;

	assign pop = out_valid_q && m_axis_tready;
	assign occ_n = 2'(out_valid_q) + 2'(skid_valid_q) + 2'(pend_q) - 2'(pop);
	assign s_axis_tready = !clr_q && occ_n <= 2'd1;
	assign take = s_axis_tvalid && s_axis_tready;

	logic [AW-1:0] pc_q, ifid_pc_q, idex_pc_q;
	logic [31:0] ifid_instr_q, idex_instr_q, exmem_instr_q, memwb_instr_q, wbend_instr_q;
	logic [31:0] idex_a_q, idex_b_q, idex_off_q;
	logic [31:0] exmem_target_q, exmem_alu_q, exmem_b_q, memwb_data_q, wbend_data_q;
	logic exmem_equal_q;
	logic [31:0] cycle_q;
	logic [31:0] regs_q [8];

	logic i_we, d_we;
	logic [AW-1:0] i_waddr, d_waddr, i_raddr, d_raddr;
	logic [31:0] i_wdata, d_wdata, i_rdata, d_rdata;
	logic i_hit_q, d_hit_q;
	logic [31:0] i_byp_q, d_byp_q, i_word, d_word;

	fspc_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_imem (
		.clk(clk), .we(i_we), .waddr(i_waddr), .wdata(i_wdata),
		.raddr(i_raddr), .rdata(i_rdata)
	);
	fspc_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_dmem (
		.clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
		.raddr(d_raddr), .rdata(d_rdata)
	);

	// A write in the cycle that reads the same entry is passed around the store.
	assign i_word = i_hit_q ? i_byp_q : i_rdata;
	assign d_word = d_hit_q ? d_byp_q : d_rdata;

	logic halted;
	logic stall, taken;
	logic [31:0] ea, eb, alu_n;
	logic [AW-1:0] pc_n, pc_inc;
	logic do_step;
	logic wbv;

	assign halted = opc(memwb_instr_q) == OPC_HALT;
	assign stall = opc(idex_instr_q) == OPC_LW &&
		(ifid_instr_q[21:19] == idex_instr_q[18:16] ||
		 ifid_instr_q[18:16] == idex_instr_q[18:16]);
	assign taken = opc(exmem_instr_q) == OPC_BEQ && exmem_equal_q;
	assign pc_inc = pc_q + 1'b1;
	assign do_step = pend_q && pend_op_q == OP_STEP && !halted;
	assign wbv = do_step && writes_reg(memwb_instr_q, 1'b1);

	always_comb begin
		ea = idex_a_q;
		eb = idex_b_q;
		if (writes_reg(wbend_instr_q, 1'b1)) begin
			if (dest_of(wbend_instr_q) == idex_instr_q[21:19]) ea = wbend_data_q;
			if (dest_of(wbend_instr_q) == idex_instr_q[18:16]) eb = wbend_data_q;
		end
		if (writes_reg(memwb_instr_q, 1'b1)) begin
			if (dest_of(memwb_instr_q) == idex_instr_q[21:19]) ea = memwb_data_q;
			if (dest_of(memwb_instr_q) == idex_instr_q[18:16]) eb = memwb_data_q;
		end
		if (writes_reg(exmem_instr_q, 1'b0)) begin
			if (exmem_instr_q[2:0] == idex_instr_q[21:19]) ea = exmem_alu_q;
			if (exmem_instr_q[2:0] == idex_instr_q[18:16]) eb = exmem_alu_q;
		end
		alu_n = exmem_alu_q;
		unique case (opc(idex_instr_q))
			OPC_ADD: alu_n = ea + eb;
			OPC_NOR: alu_n = ~(ea | eb);
			OPC_LW, OPC_SW: alu_n = ea + idex_off_q;
			default: alu_n = exmem_alu_q;
		endcase
		if (taken) pc_n = exmem_target_q[AW-1:0];
		else if (stall) pc_n = pc_q;
		else pc_n = pc_inc;
	end

	// The reads issued here serve the word executed next cycle, so they use the pc and load
	// address as they stand after the word executing now, or an accepted memory read's address.
	always_comb begin
		i_we = 1'b0;
		d_we = 1'b0;
		i_waddr = clr_cnt_q[AW-1:0];
		d_waddr = clr_cnt_q[AW-1:0];
		i_wdata = '0;
		d_wdata = '0;
		if (clr_q) begin
			i_we = 1'b1;
			d_we = 1'b1;
		end else if (pend_q && pend_op_q == OP_LOAD) begin
			i_we = 1'b1;
			d_we = 1'b1;
			i_waddr = pend_addr_q;
			d_waddr = pend_addr_q;
			i_wdata = pend_data_q;
			d_wdata = pend_data_q;
		end else if (do_step && opc(exmem_instr_q) == OPC_SW) begin
			d_we = 1'b1;
			d_waddr = exmem_alu_q[AW-1:0];
			d_wdata = exmem_b_q;
		end
		i_raddr = do_step ? pc_n : pc_q;
		d_raddr = do_step ? alu_n[AW-1:0] : exmem_alu_q[AW-1:0];
		if (take && op == OP_RDMEM) d_raddr = address[AW-1:0];
	end

	always_comb begin
		res_n = '0;
		res_n[9:0] = do_step ? 10'(pc_n) : 10'(pc_q);
		res_n[41:10] = do_step ? cycle_q + 32'd1 : cycle_q;
		res_n[42] = do_step ? opc(exmem_instr_q) == OPC_HALT : halted;
		if (wbv) begin
			res_n[43] = 1'b1;
			res_n[46:44] = dest_of(memwb_instr_q);
			res_n[78:47] = memwb_data_q;
		end
		if (do_step && opc(exmem_instr_q) == OPC_SW) begin
			res_n[79] = 1'b1;
			res_n[89:80] = 10'(exmem_alu_q[AW-1:0]);
			res_n[121:90] = exmem_b_q;
		end
		if (pend_q && pend_op_q == OP_RDMEM) res_n[153:122] = d_word;
		if (pend_q && pend_op_q == OP_RDREG) res_n[153:122] = regs_q[pend_reg_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= 1'b1;
			clr_cnt_q <= '0;
			pend_q <= 1'b0;
			pend_op_q <= '0;
			pend_reg_q <= '0;
			pend_addr_q <= '0;
			pend_data_q <= '0;
			i_hit_q <= 1'b0;
			d_hit_q <= 1'b0;
			i_byp_q <= '0;
			d_byp_q <= '0;
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
			out_q <= '0;
			skid_q <= '0;
			pc_q <= '0;
			ifid_pc_q <= '0;
			idex_pc_q <= '0;
			ifid_instr_q <= NOOP_WORD;
			idex_instr_q <= NOOP_WORD;
			exmem_instr_q <= NOOP_WORD;
			memwb_instr_q <= NOOP_WORD;
			wbend_instr_q <= NOOP_WORD;
			idex_a_q <= '0;
			idex_b_q <= '0;
			idex_off_q <= '0;
			exmem_target_q <= '0;
			exmem_alu_q <= '0;
			exmem_b_q <= '0;
			exmem_equal_q <= 1'b0;
			memwb_data_q <= '0;
			wbend_data_q <= '0;
			cycle_q <= '0;
			for (int i = 0; i < 8; i++) regs_q[i] <= '0;
		end else begin
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == (AW+1)'(MEM_WORDS - 1)) clr_q <= 1'b0;
			end
			pend_q <= take;
			if (take) begin
				pend_op_q <= op;
				pend_reg_q <= address[2:0];
				pend_addr_q <= address[AW-1:0];
				pend_data_q <= data;
			end
			i_hit_q <= i_we && i_waddr == i_raddr;
			i_byp_q <= i_wdata;
			d_hit_q <= d_we && d_waddr == d_raddr;
			d_byp_q <= d_wdata;
			if (pop) begin
				if (skid_valid_q) begin
					out_q <= skid_q;
					skid_valid_q <= pend_q;
					if (pend_q) skid_q <= res_n;
				end else begin
					out_valid_q <= pend_q;
					if (pend_q) out_q <= res_n;
				end
			end else if (pend_q) begin
				if (out_valid_q) begin
					skid_valid_q <= 1'b1;
					skid_q <= res_n;
				end else begin
					out_valid_q <= 1'b1;
					out_q <= res_n;
				end
			end
			if (do_step) begin
				cycle_q <= cycle_q + 1'b1;
				pc_q <= pc_n;
				if (!stall) begin
					ifid_instr_q <= i_word;
					ifid_pc_q <= pc_inc;
					idex_instr_q <= ifid_instr_q;
					idex_pc_q <= ifid_pc_q;
					idex_a_q <= regs_q[ifid_instr_q[21:19]];
					idex_b_q <= regs_q[ifid_instr_q[18:16]];
					idex_off_q <= {{16{ifid_instr_q[15]}}, ifid_instr_q[15:0]};
				end else begin
					idex_instr_q <= NOOP_WORD;
					idex_pc_q <= ifid_pc_q;
				end
				exmem_instr_q <= idex_instr_q;
				exmem_target_q <= 32'(idex_pc_q) + idex_off_q;
				exmem_alu_q <= alu_n;
				exmem_b_q <= eb;
				exmem_equal_q <= opc(idex_instr_q) == OPC_BEQ && ea == eb;
				memwb_instr_q <= exmem_instr_q;
				if (opc(exmem_instr_q) == OPC_ADD || opc(exmem_instr_q) == OPC_NOR)
					memwb_data_q <= exmem_alu_q;
				else if (opc(exmem_instr_q) == OPC_LW)
					memwb_data_q <= d_word;
				if (taken) begin
					ifid_instr_q <= NOOP_WORD;
					idex_instr_q <= NOOP_WORD;
					exmem_instr_q <= NOOP_WORD;
				end
				wbend_instr_q <= memwb_instr_q;
				wbend_data_q <= memwb_data_q;
				if (wbv) regs_q[dest_of(memwb_instr_q)] <= memwb_data_q;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_q;
endmodule

### design/fspc_checker.sv
module fspc_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [159:0] m_axis_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output word dropped");
	a_wb: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[43] |-> m_axis_tdata[46:44] == 3'd0)
		else $error("register index without write");
	a_st: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[79] |-> m_axis_tdata[121:90] == 32'd0)
		else $error("store value without store");
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> ##1 m_axis_tvalid)
		else $error("accepted word produced no output word");
endmodule

bind five_stage_pipeline_cpu fspc_checker u_fspc_checker (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
